FILE: rtl/core/toeq_pkg.sv
package toeq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_W      = 32;
   localparam int TAG_W       = 16;
   localparam int COUNT_W     = 5;
   localparam int STATUS_W    = 2;

   localparam logic [0:0] CMD_INSERT = 1'b0;
   localparam logic [0:0] CMD_POP    = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // count reported when the queue is full, masked to the port width
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic [0:0]        cmd;
      logic [TIME_W-1:0] event_time;
      logic [TAG_W-1:0]  event_tag;
   } req_type;

   typedef struct packed {
      logic                head_valid;
      logic [TIME_W-1:0]   head_time;
      logic [TAG_W-1:0]    head_tag;
      logic [COUNT_W-1:0]  entry_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_val;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic              ins_en;
      logic              pop_en;
      logic [TIME_W-1:0] new_time;
      logic [TAG_W-1:0]  new_tag;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/toeq_cell.sv
module toeq_cell (
   input  logic                    clock,
   input  toeq_pkg::cell_ctrl_type ctrl,
   input  logic                    occupied,
   input  logic                    left_keep,
   input  toeq_pkg::entry_type     left_entry,
   input  toeq_pkg::entry_type     right_entry,
   output logic                    keep,
   output toeq_pkg::entry_type     entry,
   output toeq_pkg::entry_type     entry_next
);
   import toeq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // sorted row: entries at or before the new time stay put
   assign keep = occupied && (entry_ff.time_val <= ctrl.new_time);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (!keep) begin
            if (left_keep) begin
               entry_in.time_val = ctrl.new_time;
               entry_in.tag      = ctrl.new_tag;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctrl.pop_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

FILE: rtl/core/timestamp_ordered_event_queue_core.sv
// Timestamp-ordered event queue.
//
// req channel: one item per operation. cmd selects insert (event_time and
// event_tag are stored) or pop of the head (event_time/event_tag ignored).
// rsp channel: exactly one item per request, showing the queue after the
// operation: head entry (zero when empty), entry count and status
// (ok, insert dropped because full, pop on empty).
//
// The queue is a row of QUEUE_DEPTH cells, one entry each. Every cell
// compares its own time with the incoming one in parallel and either holds,
// loads the new entry or takes its left neighbor (insert), or takes its right
// neighbor (pop), so all cells update together for any operation.
// The rsp item is registered and appears the cycle after the req item is accepted.
// One req item is accepted per cycle while rsp is not stalled.
// A stalled rsp item holds in the output register; req_stall is raised while
// that register is full and stalled, so no item is lost.
// Reset clears the fill count and the output valid; entry storage is not
// cleared since only occupied cells are ever read.
module timestamp_ordered_event_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  toeq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output toeq_pkg::rsp_type rsp_data
);
   import toeq_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             is_full, is_empty;
   cell_ctrl_type    ctrl;

   logic      [QUEUE_DEPTH-1:0] occ;
   logic      [QUEUE_DEPTH-1:0] keep;
   logic      [QUEUE_DEPTH-1:0] left_keep;
   entry_type                   cell_q    [QUEUE_DEPTH];
   entry_type                   cell_d    [QUEUE_DEPTH];
   entry_type                   left_ent  [QUEUE_DEPTH];
   entry_type                   right_ent [QUEUE_DEPTH];

   // output register frees up when its item is taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   assign ctrl.ins_en   = accept && (req_data.cmd == CMD_INSERT) && !is_full;
   assign ctrl.pop_en   = accept && (req_data.cmd == CMD_POP) && !is_empty;
   assign ctrl.new_time = req_data.event_time;
   assign ctrl.new_tag  = req_data.event_tag;

   // cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_keep[i] = 1'b1;
         assign left_ent[i]  = cell_q[i];
      end else begin : g_mid
         assign left_keep[i] = keep[i-1];
         assign left_ent[i]  = cell_q[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_ent[i] = cell_q[i];
      end else begin : g_inner
         assign right_ent[i] = cell_q[i+1];
      end

      toeq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ[i]),
         .left_keep   (left_keep[i]),
         .left_entry  (left_ent[i]),
         .right_entry (right_ent[i]),
         .keep        (keep[i]),
         .entry       (cell_q[i]),
         .entry_next  (cell_d[i])
      );
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result item: head comes from cell 0's next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.head_valid  = (count_in != '0);
         rsp_data_in.head_time   = (count_in != '0) ? cell_d[0].time_val : '0;
         rsp_data_in.head_tag    = (count_in != '0) ? cell_d[0].tag : '0;
         rsp_data_in.entry_count = COUNT_W'(count_in);
         if ((req_data.cmd == CMD_INSERT) && is_full) begin
            rsp_data_in.status = ST_FULL;
         end else if ((req_data.cmd == CMD_POP) && is_empty) begin
            rsp_data_in.status = ST_EMPTY;
         end else begin
            rsp_data_in.status = ST_OK;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/toeq_checker.sv
module toeq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input toeq_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_stall
);
   import toeq_pkg::*;

   // every accepted item yields a result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("no result after accepted item");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.head_valid == (rsp_data.entry_count != '0)))
      else $error("head valid disagrees with count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_FULL)) |-> (rsp_data.entry_count == FULL_COUNT))
      else $error("drop reported while not full");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_EMPTY)) |->
         (!rsp_data.head_valid && (rsp_data.head_time == '0)))
      else $error("empty pop with a head");

endmodule

bind timestamp_ordered_event_queue_core toeq_checker u_toeq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);
